@@ rtl/dcr_pkg.sv @@
// Shared constants and types for the dominance count ranker.
`default_nettype none
package dcr_pkg;
    localparam int MaxCand = 16;
    localparam int IdxW = $clog2(MaxCand);
    localparam int CntW = $clog2(MaxCand + 1);
    localparam int PtsW = $clog2(2 * MaxCand + 1);
    localparam int InW = 72;
    localparam int OutW = 16;
    localparam logic [PtsW-1:0] PtsSat = PtsW'(31);
    typedef struct packed {
        logic signed [31:0] gain;
        logic               gain_ok;
        logic signed [31:0] loss;
        logic               loss_ok;
    } t_cand;
endpackage
`default_nettype wire

@@ rtl/dominance_count_ranker.sv @@
// Top level of the dominance count ranker: load, score, sort and emit.
// An item without tlast is stored, one item a cycle while loading.
// An item with tlast starts ranking of the N held candidates: scoring
// (N reads, each accumulated, and one save per candidate), an exchange sort,
// then N results, one a cycle while the receiver is ready. Input is held off from the
// tlast transaction until the last result is registered. Reset clears control state only.
`default_nettype none
module dominance_count_ranker (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // gain[31:0], gain_valid[32], loss[64:33], loss_valid[65], zeros[71:66]
    input  wire logic [dcr_pkg::InW-1:0] s_axis_tdata,
    input  wire logic                    s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // candidate[3:0], score_points[8:4], zeros[15:9]
    output logic [dcr_pkg::OutW-1:0]     m_axis_tdata,
    output logic                         m_axis_tlast
);
    import dcr_pkg::*;

    typedef enum logic [2:0] {S_LOAD, S_SCORE, S_SAVE, S_SORT, S_EMIT} t_state;

    t_state              r_state;
    logic [CntW-1:0]     r_count;
    logic [IdxW-1:0]     r_i, r_j, r_k;
    logic                r_rd_vld;
    logic                r_rd_last;
    logic [PtsW:0]       r_acc;
    t_cand               r_self;
    t_cand               r_rd;
    t_cand               cand_mem [MaxCand];
    logic [PtsW-1:0]     pts_mem [MaxCand];
    logic [IdxW-1:0]     ord_mem [MaxCand];
    logic                r_out_vld;
    logic [IdxW-1:0]     r_out_cand;
    logic [PtsW-1:0]     r_out_pts;
    logic                r_out_last;

    t_cand               in_cand;
    logic [IdxW-1:0]     last_idx;
    logic                in_acc;
    logic [1:0]          hit;
    logic [PtsW:0]       sum;
    logic [PtsW-1:0]     sat;

    assign in_cand = t_cand'{gain: s_axis_tdata[31:0], gain_ok: s_axis_tdata[32],
                             loss: s_axis_tdata[64:33], loss_ok: s_axis_tdata[65]};
    assign s_axis_tready = (r_state == S_LOAD);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign last_idx = IdxW'(r_count - CntW'(1));

    always_comb begin
        hit[0] = r_rd.gain_ok && (r_self.gain > r_rd.gain);
        hit[1] = r_rd.loss_ok && (r_self.loss < r_rd.loss);
        sum = r_acc + (PtsW+1)'(hit[0]) + (PtsW+1)'(hit[1]);
        if (!(r_self.gain_ok && r_self.loss_ok)) sum = '0;
        sat = (r_acc > (PtsW+1)'(PtsSat)) ? PtsSat : r_acc[PtsW-1:0];
    end

    // candidate memory: one write, two registered reads (self and compared entry)
    always_ff @(posedge i_clk) begin
        if (in_acc && r_count < CntW'(MaxCand)) begin
            cand_mem[r_count[IdxW-1:0]] <= in_cand;
        end
        if (r_state == S_SCORE && r_j == '0 && !r_rd_vld) begin
            r_self <= cand_mem[r_i];
        end
        r_rd <= cand_mem[r_j];
    end

    // control state machine; sort state as small register arrays (points, order), swept in place
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_acc     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_state == S_EMIT && (!r_out_vld || m_axis_tready)) r_out_vld <= 1'b1;
            else if (m_axis_tready) r_out_vld <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (r_count < CntW'(MaxCand)) r_count <= r_count + CntW'(1);
                        if (s_axis_tlast) begin
                            r_i <= '0;
                            r_j <= '0;
                            r_acc <= '0;
                            r_rd_vld <= 1'b0;
                            r_state <= S_SCORE;
                        end
                    end
                end
                S_SCORE: begin
                    // issue reads of j, accumulate returned entries
                    r_rd_vld  <= !(r_rd_vld && r_rd_last);
                    r_rd_last <= (r_j == last_idx);
                    if (r_j != last_idx) r_j <= r_j + IdxW'(1);
                    if (r_rd_vld) begin
                        r_acc <= sum;
                        if (r_rd_last) begin
                            r_state <= S_SAVE;
                        end
                    end
                end
                S_SAVE: begin
                    pts_mem[r_i] <= sat;
                    ord_mem[r_i] <= r_i;
                    r_acc <= '0;
                    r_rd_last <= 1'b0;
                    if (r_i == last_idx) begin
                        r_i <= '0;
                        r_j <= IdxW'(1);
                        r_state <= (r_count == CntW'(1)) ? S_EMIT : S_SORT;
                        r_k <= '0;
                    end else begin
                        r_i <= r_i + IdxW'(1);
                        r_j <= '0;
                        r_state <= S_SCORE;
                    end
                end
                S_SORT: begin
                    if (pts_mem[r_j] > pts_mem[r_i]) begin
                        pts_mem[r_i] <= pts_mem[r_j];
                        pts_mem[r_j] <= pts_mem[r_i];
                        ord_mem[r_i] <= ord_mem[r_j];
                        ord_mem[r_j] <= ord_mem[r_i];
                    end
                    if (r_j == last_idx) begin
                        if (r_i + IdxW'(2) > last_idx || r_i + IdxW'(1) == last_idx) begin
                            r_state <= S_EMIT;
                            r_k <= '0;
                        end else begin
                            r_i <= r_i + IdxW'(1);
                            r_j <= r_i + IdxW'(2);
                        end
                    end else begin
                        r_j <= r_j + IdxW'(1);
                    end
                end
                S_EMIT: begin
                    if (!r_out_vld || m_axis_tready) begin
                        r_out_cand <= ord_mem[r_k];
                        r_out_pts  <= pts_mem[r_k];
                        r_out_last <= (r_k == last_idx);
                        if (r_k == last_idx) begin
                            r_count <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_k <= r_k + IdxW'(1);
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'd0, 5'(r_out_pts), 4'(r_out_cand)};
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxCand)) else $error("count overflow");
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_LOAD |-> !s_axis_tready) else $error("ready while busy");
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_count != '0) else $error("empty emit");
`endif
endmodule
`default_nettype wire

@@ verif/tb_dominance_count_ranker.sv @@
// Self-checking testbench for the dominance count ranker: stimulus, ranking predictor and checker.
`default_nettype none
module tb_dominance_count_ranker;
    timeunit 1ns;
    timeprecision 1ps;
    import dcr_pkg::*;

    typedef struct packed {
        logic [3:0] cand;
        logic [4:0] pts;
        logic       fin;
    } t_rank;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    dominance_count_ranker DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    t_cand  held_cands [MaxCand];
    int     held_count;
    t_rank  rank_queue [$];
    int     error_count = 0;
    int     cycle_count = 0;
    int     hold_off_cycles = 0;
    int     hold_off_req = 0;
    int     hold_off_seen = 0;
    bit     sink_random;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // score the held set, sort by points and queue the expected order
    task automatic rank_held_set();
        int pts [MaxCand];
        int ord [MaxCand];
        int p;
        int t;
        t_rank r;
        for (int i = 0; i < held_count; i++) begin
            p = 0;
            if (held_cands[i].gain_ok && held_cands[i].loss_ok)
                for (int j = 0; j < held_count; j++) begin
                    if (held_cands[j].gain_ok && held_cands[i].gain > held_cands[j].gain) p++;
                    if (held_cands[j].loss_ok && held_cands[i].loss < held_cands[j].loss) p++;
                end
            pts[i] = (p > 31) ? 31 : p;
            ord[i] = i;
        end
        for (int i = 0; i < held_count; i++)
            for (int j = i + 1; j < held_count; j++)
                if (pts[j] > pts[i]) begin
                    t = pts[j]; pts[j] = pts[i]; pts[i] = t;
                    t = ord[j]; ord[j] = ord[i]; ord[i] = t;
                end
        for (int k = 0; k < held_count; k++) begin
            r.cand = ord[k][3:0];
            r.pts  = pts[k][4:0];
            r.fin  = (k + 1 == held_count);
            rank_queue.push_back(r);
        end
        held_count = 0;
    endtask

    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_cand(input t_cand c, input bit lst, input bit may_gap);
        int g;
        g = may_gap ? gap_len() : 0;
        if (g != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, c.loss_ok, c.loss, c.gain_ok, c.gain};
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (held_count < MaxCand) begin
            held_cands[held_count] = c;
            held_count++;
        end
        if (lst) rank_held_set();
    endtask

    function automatic t_cand rand_cand(input int spread);
        t_cand c;
        case (spread)
            0: begin
                c.gain = $signed($urandom_range(0, 6)) - 3;
                c.loss = $signed($urandom_range(0, 6)) - 3;
            end
            default: begin
                c.gain = $urandom;
                c.loss = $urandom;
            end
        endcase
        c.gain_ok = ($urandom_range(0, 7) != 0);
        c.loss_ok = ($urandom_range(0, 7) != 0);
        return c;
    endfunction

    always @(posedge i_clk) begin
        if (hold_off_req != hold_off_seen) begin
            hold_off_seen   <= hold_off_req;
            hold_off_cycles <= 400;
            m_axis_tready   <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_random) begin
            m_axis_tready <= (gap_len() == 0) || ($urandom_range(0, 1) == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_rank got;
        t_rank exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.cand = m_axis_tdata[3:0];
            got.pts  = m_axis_tdata[8:4];
            got.fin  = m_axis_tlast;
            if (rank_queue.size() == 0) begin
                $display("%0t: unexpected result cand=%0d pts=%0d last=%0b",
                         $time, got.cand, got.pts, got.fin);
                error_count++;
            end else begin
                exp_r = rank_queue.pop_front();
                if (got !== exp_r || m_axis_tdata[15:9] !== 7'b0) begin
                    $display("%0t: expected cand=%0d pts=%0d last=%0b, got cand=%0d pts=%0d last=%0b",
                             $time, exp_r.cand, exp_r.pts, exp_r.fin,
                             got.cand, got.pts, got.fin);
                    error_count++;
                end
            end
        end
    end

    task automatic test_extremes();
        t_cand c;
        c = '{gain: 32'sh7FFFFFFF, gain_ok: 1'b1, loss: 32'sh80000000, loss_ok: 1'b1};
        send_cand(c, 1'b0, 1'b0);
        c = '{gain: 32'sh80000000, gain_ok: 1'b1, loss: 32'sh7FFFFFFF, loss_ok: 1'b1};
        send_cand(c, 1'b0, 1'b0);
        c = '{gain: 32'sh7FFFFFFF, gain_ok: 1'b0, loss: 32'sh80000000, loss_ok: 1'b1};
        send_cand(c, 1'b0, 1'b0);
        c = '{gain: 32'sh0, gain_ok: 1'b1, loss: 32'sh0, loss_ok: 1'b0};
        send_cand(c, 1'b0, 1'b0);
        c = '{gain: 32'sh0, gain_ok: 1'b1, loss: 32'sh0, loss_ok: 1'b1};
        send_cand(c, 1'b1, 1'b0);
    endtask

    task automatic test_single_and_ties();
        t_cand c;
        c = '{gain: 32'sh10000, gain_ok: 1'b1, loss: -32'sh10000, loss_ok: 1'b1};
        send_cand(c, 1'b1, 1'b0);
        for (int i = 0; i < 3; i++) send_cand(c, i == 2, 1'b0);
    endtask

    task automatic test_overflow();
        // load beyond capacity; the extras are dropped, the last still starts ranking
        for (int i = 0; i < MaxCand + 3; i++)
            send_cand(rand_cand(i % 2), i == MaxCand + 2, 1'b0);
    endtask

    task automatic test_back_pressure();
        hold_off_req++;
        for (int s = 0; s < 4; s++)
            for (int i = 0; i < 4; i++) send_cand(rand_cand(0), i == 3, 1'b0);
    endtask

    task automatic test_random_sets();
        int sent;
        int n;
        sent = 0;
        sink_random = 1'b1;
        while (sent < 200) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(MaxCand, MaxCand + 2)
                                              : $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                send_cand(rand_cand($urandom_range(0, 1)), i == n - 1, 1'b1);
            sent += n;
        end
    endtask

    initial begin
        held_count      = 0;
        sink_random     = 1'b0;
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tlast    = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_single_and_ties();
        test_overflow();
        test_back_pressure();
        test_random_sets();
        s_axis_tvalid <= 1'b0;
        while (rank_queue.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (error_count == 0 && rank_queue.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/dcr_pkg.sv
rtl/dominance_count_ranker.sv
verif/tb_dominance_count_ranker.sv
